// ===== hdl/accel_peak_hold_detector_core_defines.svh =====
// Assertion macros for the accelerometer peak-hold core.
// Used by hdl/accel_peak_hold_detector_core.sv; no other dependencies.
`ifndef ACCEL_PEAK_HOLD_DETECTOR_CORE_DEFINES_SVH
`define ACCEL_PEAK_HOLD_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define APHD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define APHD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/aphd_pkg.sv =====
// Shared constants and types for the accelerometer peak-hold core.
// No dependencies.
`default_nettype none

package aphd_pkg;

  localparam int unsigned AxisW  = 16;
  localparam int unsigned MagW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SumW   = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CFG_PEAK_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_MS        = 2'd1;

  // reset values: 1.5 g in Q4.11 and 3 s
  localparam logic [CfgW-1:0] THRESHOLD_RESET = 16'd3072;
  localparam logic [CfgW-1:0] HOLD_MS_RESET   = 16'd3000;

  // one result item
  typedef struct packed {
    logic [MagW-1:0] magnitude;
    logic [MagW-1:0] peak_value;
    logic            peak_showing;
    logic            peak_is_record;
    logic [MagW-1:0] record_value;
    logic            new_record;
    logic [CfgW-1:0] hold_left_ms;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/accel_peak_hold_detector_core.sv =====
// Accelerometer peak-hold core (depends on aphd_pkg and the _defines.svh macros). One sample
// (x, y, z in signed Q4.11 g, a millisecond stamp and a clear flag) is taken when in_valid_i
// is high and in_stall_o low; in_stall_o then stays high while the item is worked on. The
// magnitude floor(sqrt(x^2+y^2+z^2)) comes from one shared 16x16 squarer (three passes plus
// an accumulate) followed by a radix-2 digit-by-digit root, one result bit per cycle, then
// an update step for peak, record and hold expiry. An item occupies the block from accept
// to the next possible accept, the root loop being the dominant term; a stalled output
// lengthens it, since the update step waits while the output register holds an untaken
// result. Results sit in an output register (out_valid_o / out_stall_i) and a new sample
// may be accepted while one waits there. Configuration writes (index 0 threshold, 1 hold
// time, others ignored) are expected only while idle. There is no clearing pass after reset.
`default_nettype none

`include "accel_peak_hold_detector_core_defines.svh"

module accel_peak_hold_detector_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config
  input  logic                             cfg_we_i,
  input  logic [aphd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [aphd_pkg::CfgW-1:0]        cfg_data_i,
  // sample in
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [aphd_pkg::AxisW-1:0] accel_x_i,
  input  logic signed [aphd_pkg::AxisW-1:0] accel_y_i,
  input  logic signed [aphd_pkg::AxisW-1:0] accel_z_i,
  input  logic [aphd_pkg::TimeW-1:0]       now_ms_i,
  input  logic                             clear_record_i,
  // result out
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [aphd_pkg::MagW-1:0]        magnitude_o,
  output logic [aphd_pkg::MagW-1:0]        peak_value_o,
  output logic                             peak_showing_o,
  output logic                             peak_is_record_o,
  output logic [aphd_pkg::MagW-1:0]        record_value_o,
  output logic                             new_record_o,
  output logic [aphd_pkg::CfgW-1:0]        hold_left_ms_o
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQR  = 2'd1;  // squares and accumulate
  localparam logic [1:0] ST_ROOT = 2'd2;  // one root bit per cycle
  localparam logic [1:0] ST_FIN  = 2'd3;  // peak / record / expiry update

  localparam int unsigned RemW = aphd_pkg::MagW + 1;  // remainder stays <= 2*root

  logic [1:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  // latched sample
  logic signed [aphd_pkg::AxisW-1:0] ax_q, ay_q, az_q;
  logic [aphd_pkg::TimeW-1:0]        now_q;
  logic                              clr_q;

  // datapath
  logic [aphd_pkg::SumW-2:0] prod_q;
  logic [aphd_pkg::SumW-1:0] acc_q, acc_d;
  logic [RemW-1:0]           rem_q, rem_d;
  logic [aphd_pkg::MagW-1:0] root_q, root_d;

  // config and tracked state
  logic [aphd_pkg::CfgW-1:0]  thr_q, hold_q;
  logic [aphd_pkg::MagW-1:0]  held_q, held_d;
  logic [aphd_pkg::TimeW-1:0] stamp_q, stamp_d;
  logic [aphd_pkg::MagW-1:0]  rec_q, rec_d;

  logic              out_valid_q;
  aphd_pkg::result_t res_q, res_d;

  logic in_acc, out_free, fin_go;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign fin_go   = (state_q == ST_FIN) && out_free;

  assign in_stall_o = (state_q != ST_IDLE);

  // ---------------------------------------------------------------------------
  // Shared squarer: picks one axis per cycle, product registered before the add
  // ---------------------------------------------------------------------------
  logic signed [aphd_pkg::AxisW-1:0] sq_op;
  logic signed [aphd_pkg::SumW-1:0]  sq_ext;
  logic signed [aphd_pkg::SumW-1:0]  sq_full;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sq_op = ax_q;
      2'd1:    sq_op = ay_q;
      default: sq_op = az_q;
    endcase
  end

  assign sq_ext  = {{(aphd_pkg::SumW-aphd_pkg::AxisW){sq_op[aphd_pkg::AxisW-1]}}, sq_op};
  assign sq_full = sq_ext * sq_ext;

  // ---------------------------------------------------------------------------
  // Root step: bring down two bits of the sum, try (root<<2)|1
  // ---------------------------------------------------------------------------
  logic [RemW+1:0] rem_sh, trial, rem_sub;
  logic            take;

  assign rem_sh  = {rem_q, acc_q[aphd_pkg::SumW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign take    = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SQR;
          cnt_d   = '0;
          acc_d   = '0;
        end
      end
      ST_SQR: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q != 4'd0) begin
          acc_d = acc_q + {1'b0, prod_q};
        end
        if (cnt_q == 4'd3) begin
          state_d = ST_ROOT;
          cnt_d   = '0;
          rem_d   = '0;
          root_d  = '0;
        end
      end
      ST_ROOT: begin
        cnt_d  = cnt_q + 4'd1;
        acc_d  = {acc_q[aphd_pkg::SumW-3:0], 2'b00};
        rem_d  = take ? rem_sub[RemW-1:0] : rem_sh[RemW-1:0];
        root_d = {root_q[aphd_pkg::MagW-2:0], take};
        if (cnt_q == 4'd15) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Peak, record and expiry update (root_q is the magnitude here)
  // ---------------------------------------------------------------------------
  logic                       cap, expire;
  logic [aphd_pkg::MagW-1:0]  hp1, rec1;
  logic [aphd_pkg::TimeW-1:0] st1, elapsed;
  logic                       raised;

  always_comb begin
    cap    = (root_q > thr_q) && (root_q > held_q);
    hp1    = cap ? root_q : held_q;
    st1    = cap ? now_q : stamp_q;
    raised = cap && (root_q > rec_q);
    rec1   = raised ? root_q : rec_q;
    if (clr_q) begin
      hp1    = '0;
      rec1   = '0;
      raised = 1'b0;
    end
    elapsed = now_q - st1;
    expire  = (hp1 < thr_q) ||
              (elapsed > {{(aphd_pkg::TimeW-aphd_pkg::CfgW){1'b0}}, hold_q});

    held_d  = expire ? '0 : hp1;
    stamp_d = st1;
    rec_d   = rec1;

    res_d.magnitude      = root_q;
    res_d.peak_value     = held_d;
    res_d.peak_showing   = !expire;
    res_d.peak_is_record = !expire && (hp1 >= rec1);
    res_d.record_value   = rec1;
    res_d.new_record     = raised;
    res_d.hold_left_ms   = expire ? '0 : (hold_q - elapsed[aphd_pkg::CfgW-1:0]);
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= aphd_pkg::THRESHOLD_RESET;
      hold_q      <= aphd_pkg::HOLD_MS_RESET;
      held_q      <= '0;
      stamp_q     <= '0;
      rec_q       <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          aphd_pkg::CFG_PEAK_THRESHOLD: thr_q  <= cfg_data_i;
          aphd_pkg::CFG_HOLD_MS:        hold_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fin_go) begin
        held_q      <= held_d;
        stamp_q     <= stamp_d;
        rec_q       <= rec_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q  <= accel_x_i;
      ay_q  <= accel_y_i;
      az_q  <= accel_z_i;
      now_q <= now_ms_i;
      clr_q <= clear_record_i;
    end
    prod_q <= sq_full[aphd_pkg::SumW-2:0];
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    if (fin_go) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign magnitude_o      = res_q.magnitude;
  assign peak_value_o     = res_q.peak_value;
  assign peak_showing_o   = res_q.peak_showing;
  assign peak_is_record_o = res_q.peak_is_record;
  assign record_value_o   = res_q.record_value;
  assign new_record_o     = res_q.new_record;
  assign hold_left_ms_o   = res_q.hold_left_ms;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `APHD_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o, "not busy after accept")
  `APHD_ASSERT_IMP(a_peak_implies_showing, clk_i, rst_ni, out_valid_o && (peak_value_o != '0), peak_showing_o, "peak without showing")
  `APHD_ASSERT_IMP(a_record_flag_showing, clk_i, rst_ni, out_valid_o && peak_is_record_o, peak_showing_o, "record flag without showing")
  `APHD_ASSERT_IMP(a_new_record_is_mag, clk_i, rst_ni, out_valid_o && new_record_o, (record_value_o == magnitude_o) && (peak_value_o == magnitude_o) && peak_showing_o, "new record mismatch")
  `APHD_ASSERT_IMP(a_hold_left_bounded, clk_i, rst_ni, out_valid_o && !peak_showing_o, hold_left_ms_o == '0, "hold time left while not showing")

endmodule

`default_nettype wire
